/* rtl/core/lgcd_pkg.sv */
// Shared types, constants and tables of the locator distance block.
`timescale 1ns / 1ps

package lgcd_pkg;

   // Operation selector codes
   localparam logic [1:0] OP_GRID_GRID   = 2'd0;
   localparam logic [1:0] OP_GRID_POINT  = 2'd1;
   localparam logic [1:0] OP_POINT_POINT = 2'd2;
   // selector with no operation; always answered as invalid
   localparam logic [1:0] OP_UNUSED      = 2'd3;

   // Half-arcsecond angle width (signed) and its magnitude width
   localparam int HALF_W = 21;
   localparam int MAG_W  = 20;

   // CORDIC datapath
   localparam int CORDIC_STEPS = 24;
   localparam int CORDIC_W     = 36;
   localparam logic signed [CORDIC_W-1:0] CORDIC_START = 36'sd652032874;

   // Radians per half arcsecond in Q60, split for two partial products
   localparam logic [63:0] PI_Q60          = 64'h3243F6A8885A308D;
   localparam logic [63:0] RAD_PER_HALFSEC = PI_Q60 / 64'd1296000;
   localparam logic [20:0] RAD_KL          = RAD_PER_HALFSEC[20:0];
   localparam logic [20:0] RAD_KH          = RAD_PER_HALFSEC[41:21];
   localparam int ACC_W = 62;

   // Output scaling: twice the units per radian, and the clamp
   localparam logic [17:0] UNITS_X2 = 18'd203872;
   localparam logic [19:0] DIST_MAX = 20'd320242;
   localparam int PROD_W = 50;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Classified item handed from front to back
   typedef struct packed {
      logic                     ok;
      logic signed [HALF_W-1:0] h_dphi;
      logic signed [HALF_W-1:0] h_dlam;
      logic signed [HALF_W-1:0] h_sum;
   } lgcd_job_type;

   // atan(2^-i) in Q30, truncated
   function automatic logic [31:0] atan_q30(input logic [4:0] i);
      logic [31:0] a;
      case (i)
         5'd0:  a = 32'h3243F6A8;
         5'd1:  a = 32'h1DAC6705;
         5'd2:  a = 32'h0FADBAFC;
         5'd3:  a = 32'h07F56EA6;
         5'd4:  a = 32'h03FEAB76;
         5'd5:  a = 32'h01FFD55B;
         5'd6:  a = 32'h00FFFAAA;
         5'd7:  a = 32'h007FFF55;
         5'd8:  a = 32'h003FFFEA;
         5'd9:  a = 32'h001FFFFD;
         5'd10: a = 32'h000FFFFF;
         5'd11: a = 32'h0007FFFF;
         5'd12: a = 32'h0003FFFF;
         5'd13: a = 32'h0001FFFF;
         5'd14: a = 32'h0000FFFF;
         5'd15: a = 32'h00007FFF;
         5'd16: a = 32'h00003FFF;
         5'd17: a = 32'h00001FFF;
         5'd18: a = 32'h00000FFF;
         5'd19: a = 32'h000007FF;
         5'd20: a = 32'h000003FF;
         5'd21: a = 32'h000001FF;
         5'd22: a = 32'h000000FF;
         5'd23: a = 32'h0000007F;
         5'd24: a = 32'h0000003F;
         5'd25: a = 32'h0000001F;
         5'd26: a = 32'h0000000F;
         5'd27: a = 32'h00000007;
         5'd28: a = 32'h00000003;
         5'd29: a = 32'h00000001;
         default: a = 32'h00000000;
      endcase
      return a;
   endfunction

endpackage

/* rtl/core/lgcd_channels.sv */
// Request and response channel interfaces of the locator distance block.
`timescale 1ns / 1ps

interface lgcd_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         op;
   logic [47:0]        grid_a;
   logic [2:0]         len_a;
   logic [47:0]        grid_b;
   logic [2:0]         len_b;
   logic signed [19:0] point_a_lat;
   logic signed [20:0] point_a_lon;
   logic signed [19:0] point_b_lat;
   logic signed [20:0] point_b_lon;

   modport source (output valid, op, grid_a, len_a, grid_b, len_b,
                   point_a_lat, point_a_lon, point_b_lat, point_b_lon,
                   input ready);
   modport sink (input valid, op, grid_a, len_a, grid_b, len_b,
                 point_a_lat, point_a_lon, point_b_lat, point_b_lon,
                 output ready);
endinterface

interface lgcd_rsp_if;
   logic        valid;
   logic        ready;
   logic        valid_res;
   logic [18:0] distance;

   modport source (output valid, valid_res, distance, input ready);
   modport sink (input valid, valid_res, distance, output ready);
endinterface

/* rtl/core/lgcd_front.sv */
// Front end: decodes locators and points into three half-arcsecond angles.
`timescale 1ns / 1ps

module lgcd_front (
   lgcd_req_if.sink              req,
   input  logic                  q_full,
   output logic                  push,
   output lgcd_pkg::lgcd_job_type job
);

   typedef struct packed {
      logic               ok;
      logic signed [19:0] lat;
      logic signed [20:0] lon;
   } place_type;

   function automatic logic [7:0] upcase(input logic [7:0] ch);
      logic [7:0] r;
      r = ch;
      if (ch inside {["a":"z"]}) r = ch - 8'd32;
      return r;
   endfunction

   function automatic place_type decode(input logic [47:0] grid, input logic [2:0] len);
      logic [7:0]  c0, c1, c2, c3, c4, c5;
      logic [20:0] lo_u;
      logic [19:0] la_u;
      logic signed [21:0] lo_s;
      logic signed [20:0] la_s;
      place_type p;
      c0 = upcase(grid[47:40]);
      c1 = upcase(grid[39:32]);
      c2 = upcase(grid[31:24]);
      c3 = upcase(grid[23:16]);
      c4 = upcase(grid[15:8]);
      c5 = upcase(grid[7:0]);
      p.ok = (len == 3'd2 || len == 3'd4 || len == 3'd6)
          && (c0 inside {["A":"R"]}) && (c1 inside {["A":"R"]});
      if (len != 3'd2) begin
         p.ok = p.ok && (c2 inside {["0":"9"]}) && (c3 inside {["0":"9"]});
      end
      if (len == 3'd6) begin
         p.ok = p.ok && (c4 inside {["A":"X"]}) && (c5 inside {["A":"X"]});
      end
      // offsets from the southwest corner of the field grid
      lo_u = 21'(c0 - "A") * 21'd72000;
      la_u = 20'(c1 - "A") * 20'd36000;
      if (len == 3'd2) begin
         lo_u = lo_u + 21'd36000;
         la_u = la_u + 20'd18000;
      end else if (len == 3'd4) begin
         lo_u = lo_u + 21'(c2 - "0") * 21'd7200 + 21'd3600;
         la_u = la_u + 20'(c3 - "0") * 20'd3600 + 20'd1800;
      end else begin
         lo_u = lo_u + 21'(c2 - "0") * 21'd7200 + 21'(c4 - "A") * 21'd300 + 21'd150;
         la_u = la_u + 20'(c3 - "0") * 20'd3600 + 20'(c5 - "A") * 20'd150 + 20'd75;
      end
      lo_s  = $signed({1'b0, lo_u}) - 22'sd648000;
      la_s  = $signed({1'b0, la_u}) - 21'sd324000;
      p.lon = lo_s[20:0];
      p.lat = la_s[19:0];
      return p;
   endfunction

   function automatic logic signed [19:0] clamp_lat(input logic signed [19:0] v);
      logic signed [19:0] r;
      r = v;
      if (v > 20'sd324000) r = 20'sd324000;
      if (v < -20'sd324000) r = -20'sd324000;
      return r;
   endfunction

   place_type          pa, pb, p1, p2;
   logic               ok;
   logic signed [22:0] dlon;

   // Decode both locators and pick the two places
   always_comb begin
      pa = decode(req.grid_a, req.len_a);
      pb = decode(req.grid_b, req.len_b);
      p1 = pa;
      p2 = pb;
      ok = 1'b0;
      case (req.op)
         lgcd_pkg::OP_GRID_GRID: begin
            ok = pa.ok && pb.ok;
         end
         lgcd_pkg::OP_GRID_POINT: begin
            ok     = pa.ok;
            p2.lat = clamp_lat(req.point_b_lat);
            p2.lon = req.point_b_lon;
         end
         lgcd_pkg::OP_POINT_POINT: begin
            ok     = 1'b1;
            p1.lat = clamp_lat(req.point_a_lat);
            p1.lon = req.point_a_lon;
            p2.lat = clamp_lat(req.point_b_lat);
            p2.lon = req.point_b_lon;
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   // Wrap the longitude difference into one half turn either side
   always_comb begin
      dlon = 23'(p2.lon) - 23'(p1.lon);
      if (dlon >= 23'sd648000) dlon = dlon - 23'sd1296000;
      if (dlon >= 23'sd648000) dlon = dlon - 23'sd1296000;
      if (dlon < -23'sd648000) dlon = dlon + 23'sd1296000;
      if (dlon < -23'sd648000) dlon = dlon + 23'sd1296000;
   end

   // Build the item for the queue
   always_comb begin
      job.ok     = ok;
      job.h_dphi = 21'(p2.lat) - 21'(p1.lat);
      job.h_sum  = 21'(p1.lat) + 21'(p2.lat);
      job.h_dlam = dlon[20:0];
   end

   assign req.ready = !q_full;
   assign push      = req.valid && !q_full;

endmodule

/* rtl/core/lgcd_queue.sv */
// Short queue of classified items between front and back.
`timescale 1ns / 1ps

module lgcd_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  lgcd_pkg::lgcd_job_type job_in,
   output logic                   full,
   input  logic                   pop,
   output lgcd_pkg::lgcd_job_type job_out,
   output logic                   nonempty
);

   lgcd_pkg::lgcd_job_type             slot_ff [lgcd_pkg::QUEUE_DEPTH];
   logic [lgcd_pkg::QPTR_W-1:0]        wr_ff, wr_in, rd_ff, rd_in;
   logic [lgcd_pkg::QPTR_W:0]          count_ff, count_in;

   function automatic logic [lgcd_pkg::QPTR_W-1:0] bump(input logic [lgcd_pkg::QPTR_W-1:0] p);
      logic [lgcd_pkg::QPTR_W-1:0] r;
      if (p == lgcd_pkg::QPTR_W'(lgcd_pkg::QUEUE_DEPTH - 1)) r = '0;
      else r = p + 1'b1;
      return r;
   endfunction

   assign full     = (count_ff == (lgcd_pkg::QPTR_W + 1)'(lgcd_pkg::QUEUE_DEPTH));
   assign nonempty = (count_ff != '0);
   assign job_out  = slot_ff[rd_ff];

   // Advance pointers and count
   always_comb begin
      wr_in    = push ? bump(wr_ff) : wr_ff;
      rd_in    = pop ? bump(rd_ff) : rd_ff;
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= job_in;
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("item pushed into a full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset) !(pop && !nonempty))
      else $error("item popped from an empty queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (lgcd_pkg::QPTR_W + 1)'(lgcd_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");

endmodule

/* rtl/core/lgcd_back.sv */
// Back end: angle conversion, CORDIC lanes, scaling and the result register.
`timescale 1ns / 1ps

module lgcd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  lgcd_pkg::lgcd_job_type job,
   input  logic                   job_valid,
   output logic                   job_pop,
   lgcd_rsp_if.source             rsp
);

   localparam int W = lgcd_pkg::CORDIC_W;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CONV0 = 4'd1;
   localparam logic [3:0] S_CONV1 = 4'd2;
   localparam logic [3:0] S_LOAD  = 4'd3;
   localparam logic [3:0] S_ROT   = 4'd4;
   localparam logic [3:0] S_MUL   = 4'd5;
   localparam logic [3:0] S_VEC1  = 4'd6;
   localparam logic [3:0] S_SWAP  = 4'd7;
   localparam logic [3:0] S_VEC2  = 4'd8;
   localparam logic [3:0] S_SCALE = 4'd9;
   localparam logic [3:0] S_DONE  = 4'd10;

   logic [3:0] state_ff, state_in;
   logic [4:0] iter_ff, iter_in;
   logic       ok_ff, ok_in;

   logic [lgcd_pkg::MAG_W-1:0] mag_ff [3], mag_in [3];
   logic                       neg_ff [3], neg_in [3];
   logic [lgcd_pkg::ACC_W-1:0] acc_ff [3], acc_in [3];
   logic signed [W-1:0]        x_ff [3], x_in [3], y_ff [3], y_in [3], z_ff [3], z_in [3];
   logic signed [W-1:0]        sx [3], sy [3], sz [3];
   logic [lgcd_pkg::PROD_W-1:0] prod_ff, prod_in;

   logic        rsp_valid_ff, rsp_valid_in, rsp_valid_res_ff, rsp_valid_res_in;
   logic [18:0] rsp_distance_ff, rsp_distance_in;

   logic signed [lgcd_pkg::HALF_W-1:0] h_job [3];
   logic [19:0]                        dist_raw;
   logic                               last_iter;

   // Product of magnitudes rounded to Q30
   function automatic logic signed [W-1:0] mul_q30(input logic signed [W-1:0] a,
                                                   input logic signed [W-1:0] b);
      logic [31:0] ma, mb;
      logic [63:0] p;
      ma = a[W-1] ? 32'(-a) : 32'(a);
      mb = b[W-1] ? 32'(-b) : 32'(b);
      p  = ma * mb;
      return W'((p + (64'd1 << 29)) >> 30);
   endfunction

   assign h_job[0]  = job.h_dphi;
   assign h_job[1]  = job.h_dlam;
   assign h_job[2]  = job.h_sum;
   assign last_iter = (iter_ff == 5'(lgcd_pkg::CORDIC_STEPS - 1));
   assign dist_raw  = 20'((prod_ff + (lgcd_pkg::PROD_W'(1) << 29)) >> 30);

   // One CORDIC step on every lane: rotation drives z to zero, vectoring y
   always_comb begin
      logic               neg_dir;
      logic signed [W-1:0] dx, dy, a;
      for (int k = 0; k < 3; k++) begin
         dx = y_ff[k] >>> iter_ff;
         dy = x_ff[k] >>> iter_ff;
         a  = W'(lgcd_pkg::atan_q30(iter_ff));
         neg_dir = (state_ff == S_ROT) ? z_ff[k][W-1] : !y_ff[k][W-1];
         if (!neg_dir) begin
            sx[k] = x_ff[k] - dx;
            sy[k] = y_ff[k] + dy;
            sz[k] = z_ff[k] - a;
         end else begin
            sx[k] = x_ff[k] + dx;
            sy[k] = y_ff[k] - dy;
            sz[k] = z_ff[k] + a;
         end
      end
   end

   // Sequence one item through the lanes
   always_comb begin
      logic [31:0] rnd;
      state_in = state_ff;
      iter_in  = iter_ff;
      ok_in    = ok_ff;
      prod_in  = prod_ff;
      job_pop  = 1'b0;
      rnd      = '0;
      for (int k = 0; k < 3; k++) begin
         mag_in[k] = mag_ff[k];
         neg_in[k] = neg_ff[k];
         acc_in[k] = acc_ff[k];
         x_in[k]   = x_ff[k];
         y_in[k]   = y_ff[k];
         z_in[k]   = z_ff[k];
      end
      rsp_valid_in     = rsp_valid_ff && !rsp.ready;
      rsp_valid_res_in = rsp_valid_res_ff;
      rsp_distance_in  = rsp_distance_ff;
      case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               ok_in   = job.ok;
               for (int k = 0; k < 3; k++) begin
                  neg_in[k] = h_job[k][lgcd_pkg::HALF_W-1];
                  mag_in[k] = h_job[k][lgcd_pkg::HALF_W-1] ?
                              lgcd_pkg::MAG_W'(-h_job[k]) : lgcd_pkg::MAG_W'(h_job[k]);
               end
               state_in = job.ok ? S_CONV0 : S_DONE;
            end
         end
         S_CONV0: begin
            for (int k = 0; k < 3; k++) begin
               acc_in[k] = lgcd_pkg::ACC_W'(mag_ff[k] * lgcd_pkg::RAD_KL);
            end
            state_in = S_CONV1;
         end
         S_CONV1: begin
            for (int k = 0; k < 3; k++) begin
               acc_in[k] = acc_ff[k] + (lgcd_pkg::ACC_W'(mag_ff[k] * lgcd_pkg::RAD_KH) << 21);
            end
            state_in = S_LOAD;
         end
         S_LOAD: begin
            for (int k = 0; k < 3; k++) begin
               rnd     = 32'((acc_ff[k] + (lgcd_pkg::ACC_W'(1) << 29)) >> 30);
               z_in[k] = neg_ff[k] ? -W'(rnd) : W'(rnd);
               x_in[k] = lgcd_pkg::CORDIC_START;
               y_in[k] = '0;
            end
            iter_in  = '0;
            state_in = S_ROT;
         end
         S_ROT, S_VEC1, S_VEC2: begin
            for (int k = 0; k < 3; k++) begin
               x_in[k] = sx[k];
               y_in[k] = sy[k];
               z_in[k] = sz[k];
            end
            iter_in = iter_ff + 1'b1;
            if (last_iter) begin
               iter_in = '0;
               if (state_ff == S_ROT) state_in = S_MUL;
               else if (state_ff == S_VEC1) state_in = S_SWAP;
               else state_in = S_SCALE;
            end
         end
         S_MUL: begin
            // lane 0 holds the dphi sin/cos, lane 1 dlam, lane 2 the latitude sum
            x_in[0] = mul_q30(y_ff[0], x_ff[1]);
            y_in[0] = mul_q30(x_ff[2], y_ff[1]);
            x_in[1] = mul_q30(x_ff[0], x_ff[1]);
            y_in[1] = mul_q30(y_ff[2], y_ff[1]);
            z_in[0] = '0;
            z_in[1] = '0;
            state_in = S_VEC1;
         end
         S_SWAP: begin
            x_in[0]  = x_ff[1][W-1] ? '0 : x_ff[1];
            y_in[0]  = x_ff[0][W-1] ? '0 : x_ff[0];
            z_in[0]  = '0;
            state_in = S_VEC2;
         end
         S_SCALE: begin
            prod_in  = (z_ff[0] > 0) ?
                       lgcd_pkg::PROD_W'(z_ff[0][31:0] * lgcd_pkg::UNITS_X2) : '0;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in     = 1'b1;
               rsp_valid_res_in = ok_ff;
               rsp_distance_in  = !ok_ff ? '0 :
                                  (dist_raw > lgcd_pkg::DIST_MAX) ?
                                  19'(lgcd_pkg::DIST_MAX) : dist_raw[18:0];
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold datapath values
   always_ff @(posedge clock) begin
      ok_ff            <= ok_in;
      prod_ff          <= prod_in;
      rsp_valid_res_ff <= rsp_valid_res_in;
      rsp_distance_ff  <= rsp_distance_in;
      for (int k = 0; k < 3; k++) begin
         mag_ff[k] <= mag_in[k];
         neg_ff[k] <= neg_in[k];
         acc_ff[k] <= acc_in[k];
         x_ff[k]   <= x_in[k];
         y_ff[k]   <= y_in[k];
         z_ff[k]   <= z_in[k];
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.valid_res = rsp_valid_res_ff;
   assign rsp.distance  = rsp_distance_ff;

   a_done_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_valid_ff && !rsp.ready) |=> (state_ff == S_DONE && rsp_valid_ff))
      else $error("result dropped while receiver stalled");
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_valid_res_ff) |-> (rsp_distance_ff == '0))
      else $error("invalid result carries a distance");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> (state_ff == S_IDLE && job_valid))
      else $error("item taken while back end busy");

endmodule

/* rtl/core/locator_great_circle_distance.sv */
// Top level of the locator great-circle distance block.
// Each request item carries an op and two places (Maidenhead locators of
// 2, 4 or 6 characters, or latitude/longitude in arcseconds). Each
// response item gives valid_res and the haversine distance in 1/16 km.
// Channels use valid/ready; an item moves when both are high.
// The front end decodes and checks locators in the cycle of acceptance
// and writes the item into a two-entry queue, so requests keep flowing
// while the back end works. The back end runs three CORDIC lanes side by
// side: it takes the item, converts the angles (CONV0, CONV1, LOAD),
// then runs rotation, products, two vectoring passes with a swap
// between, scaling, and the load of the result register. The back end
// takes a new item only once it is idle again, so it works on one item
// at a time. An invalid item skips straight to the result register.
// The result sits in an output register; while the receiver stalls the
// back end holds its finished item and the queue keeps filling, then
// ready drops. Reset empties the queue and the output register.
`timescale 1ns / 1ps

module locator_great_circle_distance (
   input logic        clock,
   input logic        reset,
   lgcd_req_if.sink   req_ch,
   lgcd_rsp_if.source rsp_ch
);

   lgcd_pkg::lgcd_job_type front_job, back_job;
   logic                   push, full, pop, nonempty;

   // Classify items
   lgcd_front u_front (
      .req    (req_ch),
      .q_full (full),
      .push   (push),
      .job    (front_job)
   );

   // Decouple front and back
   lgcd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .job_in   (front_job),
      .full     (full),
      .pop      (pop),
      .job_out  (back_job),
      .nonempty (nonempty)
   );

   // Compute the distance
   lgcd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job       (back_job),
      .job_valid (nonempty),
      .job_pop   (pop),
      .rsp       (rsp_ch)
   );

endmodule
